/* hw/rtl/kmp_pkg.sv */
// Shared types and constants for the pattern matcher.
`default_nettype none
package kmp_pkg;

	// Longest pattern held, and the width of the text position counter.
	localparam int MAX_PATTERN   = 64;
	localparam int POSITION_BITS = 20;

	// Widths for lengths, start positions and differences.
	localparam int LEN_BITS   = $clog2(MAX_PATTERN + 1);
	localparam int START_BITS = 20;
	localparam int DIFF_BITS  = (POSITION_BITS + 1 > LEN_BITS) ? POSITION_BITS + 1 : LEN_BITS;

	// Kind of byte carried by an input transfer.
	typedef enum logic {
		CMD_PATTERN = 1'b0,
		CMD_TEXT    = 1'b1
	} cmd_t;

	// Search status reported for each text byte.
	typedef enum logic [1:0] {
		ST_SEARCH    = 2'd0,
		ST_MATCH     = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// Input item.
	typedef struct packed {
		cmd_t       command;
		logic [7:0] symbol;
		logic       first;
		logic       last;
	} req_t;

	// Result item.
	typedef struct packed {
		status_t                 status;
		logic [START_BITS-1:0]   match_start;
	} rsp_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic load;     // a pattern byte is written
		logic restart;  // the pattern byte starts a new pattern
		logic step;     // a text byte advances the search
		logic fresh;    // the text byte starts a new text
	} cell_ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/kmp_pattern_matcher.sv */
// Top level of the streaming pattern matcher.
// Pattern bytes (command 0) are written into a chain of MAX_PATTERN cells, one byte
// per cell; first starts a new pattern and bytes beyond MAX_PATTERN are dropped. Text
// bytes (command 1) are compared in every cell at once and each cell hands its
// prefix-match flag to its right neighbor, so the search is exactly that of the
// Knuth-Morris-Pratt automaton. One item can be accepted in every cycle while req_stall
// is low: the only loop is the update of the cell flags. Each searched text byte gives
// one result (searching, match with its start position, or not found on a last byte);
// after a match text bytes give nothing until a byte with first set. Pattern bytes give
// no result and end the current text. req_stall rises only while the output register
// and its skid entry are full.
`default_nettype none
module kmp_pattern_matcher (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire kmp_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output kmp_pkg::rsp_t      rsp
);
	import kmp_pkg::*;

	cell_ctrl_t ctrl;
	logic       accept;
	logic       buf_full;

	logic [MAX_PATTERN-1:0] tok_eff_vec;
	logic [MAX_PATTERN-1:0] tok_vec;
	logic [MAX_PATTERN-1:0] act_vec;
	logic [MAX_PATTERN-1:0] hit_vec;

	logic                     pending_q;
	logic                     full_q;
	logic [LEN_BITS-1:0]      len_q;
	logic [LEN_BITS-1:0]      len_base;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] pos_eff;
	logic                     found_q;
	logic                     hit_any;
	logic [DIFF_BITS-1:0]     end_pos;
	logic [DIFF_BITS-1:0]     len_ext;
	logic [DIFF_BITS-1:0]     start;
	logic                     res_valid;
	rsp_t                     res;

	// Decode an accepted transfer into cell control.
	always_comb begin
		accept       = req_valid & ~req_stall;
		ctrl.load    = accept & (req.command == CMD_PATTERN);
		ctrl.restart = ctrl.load & (req.first | pending_q);
		ctrl.step    = accept & (req.command == CMD_TEXT) & (req.first | ~found_q);
		ctrl.fresh   = req.first;
	end

	// The chain of cells.
	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic tok_left;
		logic tok_right;
		logic act_left;
		if (i == 0) begin : g_head
			assign tok_left = 1'b0;
			assign act_left = 1'b0;
		end else begin : g_body
			assign tok_left = tok_eff_vec[i-1];
			assign act_left = act_vec[i-1];
		end
		if (i == MAX_PATTERN - 1) begin : g_tail
			assign tok_right = full_q;
		end else begin : g_inner
			assign tok_right = tok_vec[i+1];
		end
		kmp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.symbol    (req.symbol),
			.head      (i == 0),
			.tok_left  (tok_left),
			.tok_right (tok_right),
			.act_left  (act_left),
			.tok_eff   (tok_eff_vec[i]),
			.tok_o     (tok_vec[i]),
			.act_o     (act_vec[i]),
			.hit       (hit_vec[i])
		);
	end

	// Result of the current text byte.
	always_comb begin
		hit_any   = |hit_vec;
		pos_eff   = req.first ? '0 : pos_q;
		end_pos   = DIFF_BITS'(pos_eff) + DIFF_BITS'(1);
		len_ext   = DIFF_BITS'(len_q);
		start     = (end_pos >= len_ext) ? end_pos - len_ext : '0;
		len_base  = ctrl.restart ? '0 : len_q;
		res_valid = ctrl.step;
		if (hit_any) begin
			res.status      = ST_MATCH;
			res.match_start = START_BITS'(start);
		end else begin
			res.status      = req.last ? ST_NOT_FOUND : ST_SEARCH;
			res.match_start = '0;
		end
	end

	// Pattern length, full flag and text search state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b1;
			full_q    <= 1'b0;
			len_q     <= '0;
			pos_q     <= '0;
			found_q   <= 1'b0;
		end else if (ctrl.load) begin
			pending_q <= 1'b0;
			full_q    <= tok_eff_vec[MAX_PATTERN-1] | (full_q & ~ctrl.restart);
			if (len_base != LEN_BITS'(MAX_PATTERN)) begin
				len_q <= len_base + LEN_BITS'(1);
			end else begin
				len_q <= len_base;
			end
			pos_q     <= '0;
			found_q   <= 1'b0;
		end else if (ctrl.step) begin
			pos_q     <= (pos_eff == '1) ? pos_eff : pos_eff + POSITION_BITS'(1);
			found_q   <= hit_any;
		end
	end

	// Output register and skid entry.
	kmp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.full      (buf_full),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	assign req_stall = buf_full;

	// At most one cell, or the full flag, holds the write token.
	a_token_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({full_q, tok_vec}))
		else $error("write token held in more than one place");

	// The full flag agrees with the pattern length.
	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		full_q == (len_q == LEN_BITS'(MAX_PATTERN)))
		else $error("full flag disagrees with pattern length");

	// An empty pattern never reports a match.
	a_empty_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == '0) |-> !hit_any)
		else $error("match reported for an empty pattern");

	// Text bytes after a match are not searched until a new text begins.
	a_found_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && !req.first) |-> !ctrl.step)
		else $error("search advanced after a match");

endmodule
`default_nettype wire

/* hw/rtl/kmp_cell.sv */
// One cell of the matching chain: a pattern byte, a write token and a prefix-match flag.
`default_nettype none
module kmp_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire kmp_pkg::cell_ctrl_t ctrl,
	input  wire logic [7:0]          symbol,
	input  wire logic                head,
	input  wire logic                tok_left,
	input  wire logic                tok_right,
	input  wire logic                act_left,
	output logic                     tok_eff,
	output logic                     tok_o,
	output logic                     act_o,
	output logic                     hit
);
	import kmp_pkg::*;

	logic [7:0] pattern_q;
	logic       token_q;
	logic       act_q;
	logic       act_next;

	// On a restart the head cell takes the token; otherwise the stored token counts.
	assign tok_eff = ctrl.restart ? head : token_q;
	assign tok_o   = token_q;
	assign act_o   = act_q;

	// The prefix ending here matches if the shorter prefix matched and this byte agrees.
	assign act_next = (head | (act_left & ~ctrl.fresh)) & (symbol == pattern_q);

	// This cell holds the final pattern byte when the token sits just to its right.
	assign hit = act_next & tok_right;

	// Pattern byte storage, written where the token sits.
	always_ff @(posedge clk) begin
		if (ctrl.load && tok_eff) begin
			pattern_q <= symbol;
		end
	end

	// Token and match flag move one cell to the right.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_q <= 1'b0;
			act_q   <= 1'b0;
		end else if (ctrl.load) begin
			token_q <= tok_left;
			act_q   <= 1'b0;
		end else if (ctrl.step) begin
			act_q   <= act_next;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/kmp_out_buf.sv */
// Output register with one skid entry for result transfers.
`default_nettype none
module kmp_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          res_valid,
	input  wire kmp_pkg::rsp_t res,
	output logic               full,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output kmp_pkg::rsp_t      rsp
);
	import kmp_pkg::*;

	logic out_valid_q;
	logic skid_valid_q;
	rsp_t out_q;
	rsp_t skid_q;
	logic out_free;

	assign out_free  = ~out_valid_q | ~rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign full      = skid_valid_q;

	// Valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | res_valid;
			skid_valid_q <= skid_valid_q & res_valid;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload: the skid entry drains first so order is kept.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q  <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	// The skid entry is only used while the output register is occupied.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds data while output register is empty");

	// A stalled result with a full skid entry blocks new results.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_valid_q && rsp_stall) |-> !res_valid)
		else $error("result arrived while both entries were occupied");

	// A held result stays in place.
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_stall) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result changed");

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the streaming KMP pattern matcher.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import kmp_pkg::*;

	localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS) - 1;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int TAIL_CYCLES = 16;
	localparam int RANDOM_GOAL = 250;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	// Matcher state as predicted from the accepted transfers.
	logic [7:0]      pat_bytes [MAX_PATTERN];
	int              fail_link [MAX_PATTERN + 1];
	int              pat_len = 0;
	int              build_j = -1;
	int              srch_j = 0;
	longint unsigned text_pos = 0;
	bit              found = 1'b0;

	// Results still owed by the block, oldest first.
	rsp_t expected_status [$];

	int errors = 0;
	int results_checked = 0;
	int matches_seen = 0;
	int not_found_seen = 0;
	int sent_count = 0;
	int ignored_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;

	kmp_pattern_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Free-running clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Advance the search model by one accepted transfer and queue its result, if any.
	function automatic void kmp_step(input req_t item);
		int              j;
		longint unsigned end_pos;
		longint unsigned start_pos;
		rsp_t            res;
		if (item.command == CMD_PATTERN) begin
			if (item.first) begin
				pat_len = 0;
				build_j = -1;
				fail_link[0] = -1;
			end
			// Extend the failure table online; bytes past the store are dropped.
			if (pat_len < MAX_PATTERN) begin
				pat_bytes[pat_len] = item.symbol;
				j = build_j;
				while (j >= 0 && j < MAX_PATTERN && item.symbol != pat_bytes[j])
					j = fail_link[j];
				pat_len++;
				j++;
				fail_link[pat_len] = j;
				build_j = j;
			end
			srch_j = 0;
			text_pos = 0;
			found = 1'b0;
			return;
		end
		if (item.first) begin
			srch_j = 0;
			text_pos = 0;
			found = 1'b0;
		end
		if (found) begin
			ignored_count++;
			return;
		end
		res.status = ST_SEARCH;
		res.match_start = '0;
		// Walk the failure links until the byte extends a prefix or none is left.
		if (pat_len > 0) begin
			j = srch_j;
			while (j >= 0 && j < pat_len && item.symbol != pat_bytes[j])
				j = fail_link[j];
			j++;
			if (j >= pat_len) begin
				end_pos = text_pos + 1;
				start_pos = (end_pos >= longint'(pat_len)) ? end_pos - pat_len : 0;
				found = 1'b1;
				res.status = ST_MATCH;
				res.match_start = start_pos[START_BITS-1:0];
				srch_j = 0;
			end else begin
				srch_j = j;
			end
		end
		if (text_pos < POS_LIMIT)
			text_pos++;
		if (!found && item.last)
			res.status = ST_NOT_FOUND;
		expected_status.push_back(res);
	endfunction

	// Track accepted inputs and compare each accepted result with the oldest expectation.
	always @(posedge clk) begin : check_results
		rsp_t want;
		cycle_count++;
		if (arst_n) begin
			if (req_valid && !req_stall)
				kmp_step(req);
			if (rsp_valid && !rsp_stall) begin
				if (expected_status.size() == 0) begin
					errors++;
					$display("%0t: unexpected result status=%0d start=%0d", $time,
						rsp.status, rsp.match_start);
				end else begin
					want = expected_status.pop_front();
					results_checked++;
					if (want.status == ST_MATCH)
						matches_seen++;
					if (want.status == ST_NOT_FOUND)
						not_found_seen++;
					if (rsp.status !== want.status) begin
						errors++;
						$display("%0t: status mismatch, expected %0d, actual %0d", $time,
							want.status, rsp.status);
					end
					if (rsp.match_start !== want.match_start) begin
						errors++;
						$display("%0t: match_start mismatch, expected %0d, actual %0d",
							$time, want.match_start, rsp.match_start);
					end
				end
			end
		end
	end

	// Receiver back-pressure, changed on the falling edge.
	always @(negedge clk) begin
		if (arst_n)
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	// Drive one transfer, with optional idle cycles ahead of it, and wait for acceptance.
	task automatic send_item(input cmd_t cmd, input logic [7:0] sym, input logic is_first,
			input logic is_last);
		req_t item;
		item.command = cmd;
		item.symbol = sym;
		item.first = is_first;
		item.last = is_last;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (req_stall);
		sent_count++;
	endtask

	// Stop sending and wait until every owed result has arrived.
	task automatic wait_for_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Text against an empty pattern never matches.
	task automatic test_empty_pattern();
		send_item(CMD_TEXT, 8'h00, 1'b1, 1'b0);
		send_item(CMD_TEXT, 8'hFF, 1'b0, 1'b1);
	endtask

	// Match with a failure-link fallback, silence after a match, and continuation past last.
	task automatic test_match_and_restart();
		send_item(CMD_PATTERN, "A", 1'b1, 1'b0);
		send_item(CMD_PATTERN, "A", 1'b0, 1'b1);
		send_item(CMD_PATTERN, "B", 1'b0, 1'b0);
		send_item(CMD_TEXT, "A", 1'b1, 1'b0);
		send_item(CMD_TEXT, "A", 1'b0, 1'b0);
		send_item(CMD_TEXT, "A", 1'b0, 1'b0);
		send_item(CMD_TEXT, "B", 1'b0, 1'b0);
		send_item(CMD_TEXT, "X", 1'b0, 1'b1);
		send_item(CMD_TEXT, "A", 1'b1, 1'b0);
		send_item(CMD_TEXT, "B", 1'b0, 1'b1);
		send_item(CMD_TEXT, "A", 1'b0, 1'b0);
		send_item(CMD_TEXT, "A", 1'b0, 1'b0);
		send_item(CMD_TEXT, "B", 1'b0, 1'b1);
	endtask

	// A pattern byte in the middle of a text extends the pattern and restarts the text.
	task automatic test_pattern_mid_text();
		send_item(CMD_TEXT, "A", 1'b1, 1'b0);
		send_item(CMD_PATTERN, "C", 1'b0, 1'b0);
		send_item(CMD_TEXT, "A", 1'b0, 1'b0);
		send_item(CMD_TEXT, "A", 1'b0, 1'b0);
		send_item(CMD_TEXT, "B", 1'b0, 1'b0);
		send_item(CMD_TEXT, "C", 1'b0, 1'b0);
	endtask

	// Smallest and largest byte values; a match on a last byte reports the match.
	task automatic test_symbol_extremes();
		send_item(CMD_PATTERN, 8'hFF, 1'b1, 1'b1);
		send_item(CMD_TEXT, 8'h00, 1'b1, 1'b0);
		send_item(CMD_TEXT, 8'hFF, 1'b0, 1'b1);
		wait_for_results();
	endtask

	// One random session: mostly a pattern and texts over a small alphabet, else noise.
	task automatic run_session();
		logic [7:0] base;
		logic [7:0] sym;
		logic [7:0] pat_q [$];
		int         alpha;
		int         plen;
		int         tlen;
		int         at;
		int         k;
		int         t;
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(1, 8))
				send_item(cmd_t'($urandom_range(1)), 8'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			return;
		end
		base = 8'($urandom_range(255));
		alpha = $urandom_range(1, 3);
		plen = ($urandom_range(99) < 6) ? $urandom_range(60, 70) : $urandom_range(1, 6);
		// The pattern; now and then it extends the previous one instead.
		for (k = 0; k < plen; k++) begin
			sym = base + 8'($urandom_range(alpha - 1));
			pat_q.push_back(sym);
			send_item(CMD_PATTERN, sym, (k == 0) && ($urandom_range(9) != 0),
				1'($urandom_range(1)));
		end
		// Texts, about half of them holding a planted copy of the pattern.
		for (t = $urandom_range(1, 3); t > 0; t--) begin
			tlen = $urandom_range(1, (plen > 20) ? plen + 10 : 24);
			at = ($urandom_range(1) == 1 && tlen >= plen) ? $urandom_range(tlen - plen) : -1;
			for (k = 0; k < tlen; k++) begin
				if (at >= 0 && k >= at && k < at + plen)
					sym = pat_q[k - at];
				else
					sym = base + 8'($urandom_range(alpha - 1));
				if ($urandom_range(99) < 2)
					send_item(CMD_PATTERN, base + 8'($urandom_range(alpha - 1)), 1'b0, 1'b0);
				send_item(CMD_TEXT, sym, (k == 0) && ($urandom_range(9) != 0),
					(k == tlen - 1) && ($urandom_range(9) != 0));
			end
		end
	endtask

	// Random sessions under one idle and stall setting until enough transfers other than ignored text bytes went in.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct);
		int sent0;
		int ignored0;
		send_idle_pct = idle_pct;
		rsp_stall_pct = stall_pct;
		sent0 = sent_count;
		ignored0 = ignored_count;
		while ((sent_count - sent0) - (ignored_count - ignored0) < RANDOM_GOAL)
			run_session();
		wait_for_results();
	endtask

	// Watchdog on the cycle counter.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("%0t: timeout with %0d results outstanding", $time, expected_status.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// Reset, then run the tests in turn.
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		fail_link[0] = -1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_pattern();
		test_match_and_restart();
		test_pattern_mid_text();
		test_symbol_extremes();
		test_random_traffic(0, 0);
		test_random_traffic(45, 0);
		test_random_traffic(0, 45);
		test_random_traffic(22, 22);
		$display("Run sent %0d transfers and checked %0d text results.", sent_count,
			results_checked);
		$display("Of those, %0d were matches and %0d texts ended without one; %0d errors.",
			matches_seen, not_found_seen, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
